// File: sv/sscol_pkg.sv
// shared types, widths and codes for the sorted sparse column table
package sscol_pkg;

  // table geometry
  localparam int CAPACITY = 32;
  localparam int COL_BITS = 14;
  localparam int VAL_BITS = 32;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int SPAN_W   = COL_BITS + 1;
  localparam int ENTRY_W  = VAL_BITS + 1;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_TOUCH  = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_ABSENT  = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                ins_en;
    logic                ers_en;
    logic                set_en;
    logic [COL_BITS-1:0] col;
    logic [ENTRY_W-1:0]  entry;
  } cell_cmd_t;

endpackage

// File: sv/sscol_cell.sv
// one slot of the sorted row: compares against the request and shifts with its neighbors
module sscol_cell import sscol_pkg::*; (
  input  logic                clk,
  input  cell_cmd_t           cmd,
  input  logic                valid,
  input  logic                left_lt,
  input  logic [COL_BITS-1:0] left_key,
  input  logic [ENTRY_W-1:0]  left_val,
  input  logic [COL_BITS-1:0] right_key,
  input  logic [ENTRY_W-1:0]  right_val,
  output logic                lt,
  output logic                eq,
  output logic [COL_BITS-1:0] key,
  output logic [ENTRY_W-1:0]  val
);

  logic at_pos;
  logic after_pos;

  // compare against the requested column
  assign lt        = valid && (key < cmd.col);
  assign eq        = valid && (key == cmd.col);
  assign at_pos    = !lt && left_lt;
  assign after_pos = !lt && !left_lt;

  // insert shifts up from the left, erase pulls down from the right
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (at_pos) begin
        key <= cmd.col;
        val <= cmd.entry;
      end else if (after_pos) begin
        key <= left_key;
        val <= left_val;
      end
    end else if (cmd.ers_en) begin
      if (!lt) begin
        key <= right_key;
        val <= right_val;
      end
    end else if (cmd.set_en && eq) begin
      val <= cmd.entry;
    end
  end

endmodule

// File: sv/sorted_sparse_column_table_unit.sv
// top level of the sorted sparse column table: request control, cell row and result register
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata, s_tuser (one operation)
//  m_*       out  m_tvalid/m_tready  m_tdata, m_tuser (one result)
//
// each request goes through capture, parallel compare and shift across the cell
// row, then span read from the new last cell into the result register.
// reset empties the table (the entry count goes to zero).
// a held result stalls only the final step; the next request is taken as soon
// as the previous one has been moved to the result register.
module sorted_sparse_column_table_unit import sscol_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // operation[1:0], column[15:2], value_word[47:16]
  input  logic        s_tuser,  // value_is_null
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // status[1:0], was_present[2], result_value[34:3],
                                // span_count[49:35], entry_count[55:50]
  output logic        m_tuser   // result_null
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state;
  logic [1:0]          req_op;
  logic [COL_BITS-1:0] req_col;
  logic [VAL_BITS-1:0] req_word;
  logic                req_null;
  logic [OCC_W-1:0]    occ;

  logic [1:0]          res_status;
  logic                res_present;
  logic [VAL_BITS-1:0] res_value;
  logic                res_null;

  logic [1:0]          out_status;
  logic                out_present;
  logic [VAL_BITS-1:0] out_value;
  logic                out_null;
  logic [SPAN_W-1:0]   out_span;
  logic [OCC_W-1:0]    out_count;

  cell_cmd_t           cmd;
  logic [CAPACITY-1:0] c_valid;
  logic [CAPACITY-1:0] c_lt;
  logic [CAPACITY-1:0] c_eq;
  logic [COL_BITS-1:0] c_key [CAPACITY];
  logic [ENTRY_W-1:0]  c_val [CAPACITY];

  logic                present;
  logic                full;
  logic [ENTRY_W-1:0]  hit_val;
  logic [ENTRY_W-1:0]  new_entry;
  logic [COL_BITS-1:0] last_key;
  logic [SPAN_W-1:0]   span;
  logic                is_ins;
  logic                fin_go;

  assign s_tready = (state == S_IDLE);
  assign fin_go   = (state == S_FIN) && (!m_tvalid || m_tready);

  // request decode
  assign new_entry = ((req_op == OP_SET) && !req_null) ? {1'b0, req_word}
                                                       : {1'b1, {VAL_BITS{1'b0}}};
  assign present   = |c_eq;
  assign full      = (occ == OCC_W'(CAPACITY));
  assign is_ins    = ((req_op == OP_SET) || (req_op == OP_TOUCH)) && !present && !full;

  always_comb begin
    cmd.ins_en = (state == S_EXEC) && is_ins;
    cmd.ers_en = (state == S_EXEC) && (req_op == OP_ERASE) && present;
    cmd.set_en = (state == S_EXEC) && (req_op == OP_SET) && present;
    cmd.col    = req_col;
    cmd.entry  = new_entry;
  end

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                l_lt;
    logic [COL_BITS-1:0] l_key;
    logic [ENTRY_W-1:0]  l_val;
    logic [COL_BITS-1:0] r_key;
    logic [ENTRY_W-1:0]  r_val;

    assign c_valid[i] = (OCC_W'(i) < occ);

    if (i == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_key = req_col;
      assign l_val = new_entry;
    end else begin : g_mid
      assign l_lt  = c_lt[i-1];
      assign l_key = c_key[i-1];
      assign l_val = c_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_key = c_key[i];
      assign r_val = c_val[i];
    end else begin : g_inner
      assign r_key = c_key[i+1];
      assign r_val = c_val[i+1];
    end

    sscol_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .valid     (c_valid[i]),
      .left_lt   (l_lt),
      .left_key  (l_key),
      .left_val  (l_val),
      .right_key (r_key),
      .right_val (r_val),
      .lt        (c_lt[i]),
      .eq        (c_eq[i]),
      .key       (c_key[i]),
      .val       (c_val[i])
    );
  end

  // hit value and last key gathered across the row
  always_comb begin
    hit_val  = '0;
    last_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (c_eq[i]) begin
        hit_val = hit_val | c_val[i];
      end
      if (OCC_W'(i + 1) == occ) begin
        last_key = last_key | c_key[i];
      end
    end
  end

  assign span = (occ == '0) ? '0 : (SPAN_W'(last_key) + SPAN_W'(1));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.ins_en) begin
            occ <= occ + OCC_W'(1);
          end else if (cmd.ers_en) begin
            occ <= occ - OCC_W'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op   <= s_tdata[1:0];
      req_col  <= s_tdata[15:2];
      req_word <= s_tdata[47:16];
      req_null <= s_tuser;
    end
  end

  // result of the compare step
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_present <= present;
      if (present) begin
        res_status <= STS_OK;
        if (req_op == OP_ERASE) begin
          res_null  <= 1'b1;
          res_value <= '0;
        end else if (req_op == OP_SET) begin
          res_null  <= new_entry[VAL_BITS];
          res_value <= new_entry[VAL_BITS-1:0];
        end else begin
          res_null  <= hit_val[VAL_BITS];
          res_value <= hit_val[VAL_BITS] ? '0 : hit_val[VAL_BITS-1:0];
        end
      end else if ((req_op == OP_LOOKUP) || (req_op == OP_ERASE)) begin
        res_status <= STS_ABSENT;
        res_null   <= 1'b1;
        res_value  <= '0;
      end else if (full) begin
        res_status <= STS_FULL;
        res_null   <= 1'b1;
        res_value  <= '0;
      end else begin
        res_status <= STS_OK;
        res_null   <= new_entry[VAL_BITS];
        res_value  <= new_entry[VAL_BITS-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_status  <= res_status;
      out_present <= res_present;
      out_value   <= res_value;
      out_null    <= res_null;
      out_span    <= span;
      out_count   <= occ;
    end
  end

  assign m_tdata = {out_count, out_span, out_value, out_present, out_status};
  assign m_tuser = out_null;

endmodule

// File: sv/sscol_checker.sv
// port-level checks for the sorted sparse column table, bound to the top level
module sscol_checker import sscol_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // an empty table has no span
  a_empty_span: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[55:50] == '0) |-> (m_tdata[49:35] == '0))
    else $error("span nonzero with empty table");

  // full status only when the table holds every slot
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == STS_FULL) |-> (m_tdata[55:50] == OCC_W'(CAPACITY)))
    else $error("full status with free slots");

  // failed requests report an absent value
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != STS_OK) |-> m_tuser && (m_tdata[34:3] == '0))
    else $error("failed request carries a value");

  // absent status never comes with a present column
  a_absent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == STS_ABSENT) |-> !m_tdata[2])
    else $error("absent status on a present column");

endmodule

bind sorted_sparse_column_table_unit sscol_checker u_sscol_checker (.*);

// File: dv/sorted_sparse_column_table_unit_tb.sv
// self-checking testbench for the sorted sparse column table unit
`timescale 1ns / 100ps

module sorted_sparse_column_table_unit_tb;
  import sscol_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned POOL_SIZE   = 40;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned LONG_HOLD   = 300;

  // operation mix used by a random phase
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  // one result as the table reports it
  typedef struct packed {
    logic [1:0]          status;
    logic                was_present;
    logic [VAL_BITS-1:0] value;
    logic                value_null;
    logic [SPAN_W-1:0]   span;
    logic [OCC_W-1:0]    entries;
  } table_reply_t;

  // mirror of the sorted table plus the replies it still owes
  class column_table_tracker;
    logic [COL_BITS-1:0] keys  [CAPACITY];
    logic [ENTRY_W-1:0]  slots [CAPACITY];
    int unsigned         fill;
    table_reply_t        due_replies [$];
    int unsigned         mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    // apply one accepted request to the mirror and queue its reply
    function void note_request(logic [1:0] op, logic [COL_BITS-1:0] col,
                               logic [VAL_BITS-1:0] word, logic nul);
      int unsigned        pos;
      int unsigned        i;
      bit                 present;
      logic [ENTRY_W-1:0] entry;
      table_reply_t       r;
      pos = 0;
      while (pos < fill && keys[pos] < col) pos++;
      present       = (pos < fill) && (keys[pos] == col);
      r             = '0;
      r.status      = STS_OK;
      r.was_present = present;
      r.value_null  = 1'b1;
      if (present) begin
        if (op == OP_SET) slots[pos] = nul ? {1'b1, {VAL_BITS{1'b0}}} : {1'b0, word};
        if (op == OP_ERASE) begin
          for (i = pos; i + 1 < fill; i++) begin
            keys[i]  = keys[i + 1];
            slots[i] = slots[i + 1];
          end
          fill--;
        end else begin
          r.value_null = slots[pos][VAL_BITS];
          r.value      = r.value_null ? '0 : slots[pos][VAL_BITS-1:0];
        end
      end else if (op == OP_LOOKUP || op == OP_ERASE) begin
        r.status = STS_ABSENT;
      end else if (fill >= CAPACITY) begin
        r.status = STS_FULL;
      end else begin
        entry = (op == OP_SET && !nul) ? {1'b0, word} : {1'b1, {VAL_BITS{1'b0}}};
        for (i = fill; i > pos; i--) begin
          keys[i]  = keys[i - 1];
          slots[i] = slots[i - 1];
        end
        keys[pos]    = col;
        slots[pos]   = entry;
        fill++;
        r.value_null = entry[VAL_BITS];
        r.value      = r.value_null ? '0 : entry[VAL_BITS-1:0];
      end
      r.span    = (fill == 0) ? '0 : SPAN_W'(keys[fill - 1]) + 1'b1;
      r.entries = OCC_W'(fill);
      due_replies.push_back(r);
    endfunction

    // compare one accepted result with the oldest owed reply
    function void check_reply(logic [55:0] data, logic nul);
      table_reply_t got;
      table_reply_t want;
      got.status      = data[1:0];
      got.was_present = data[2];
      got.value       = data[34:3];
      got.span        = data[49:35];
      got.entries     = data[55:50];
      got.value_null  = nul;
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d pres=%0b val=%h null=%0b span=%0d n=%0d",
                   got.status, got.was_present, got.value, got.value_null,
                   got.span, got.entries);
      end else begin
        want = due_replies.pop_front();
        if (got.status !== want.status || got.was_present !== want.was_present ||
            got.value !== want.value || got.value_null !== want.value_null ||
            got.span !== want.span || got.entries !== want.entries) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("result differs: expected st=%0d pres=%0b val=%h null=%0b span=%0d n=%0d",
                   want.status, want.was_present, want.value, want.value_null,
                   want.span, want.entries);
            $display(", got st=%0d pres=%0b val=%h null=%0b span=%0d n=%0d",
                     got.status, got.was_present, got.value, got.value_null,
                     got.span, got.entries);
          end
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // operation[1:0], column[15:2], value_word[47:16]
  logic        s_tuser;   // value_is_null
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // status[1:0], was_present[2], result_value[34:3],
                          // span_count[49:35], entry_count[55:50]
  logic        m_tuser;   // result_null

  column_table_tracker tracker = new();

  bit                  source_idle;
  bit                  sink_idle;
  int unsigned         hold_request;
  logic [COL_BITS-1:0] col_pool [POOL_SIZE];
  op_mix_t             phase_mix [PHASES];

  sorted_sparse_column_table_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sender gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [1:0] pick_op(op_mix_t mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 15) return OP_LOOKUP;
        if (roll < 55) return OP_SET;
        if (roll < 85) return OP_TOUCH;
        return OP_ERASE;
      end
      MIX_DRAIN: begin
        if (roll < 20) return OP_LOOKUP;
        if (roll < 30) return OP_SET;
        if (roll < 40) return OP_TOUCH;
        return OP_ERASE;
      end
      default: return 2'($urandom_range(0, 3));
    endcase
  endfunction

  // mostly pool keys so requests hit stored entries, some fully random keys
  function automatic logic [COL_BITS-1:0] pick_column();
    if ($urandom_range(0, 99) < 88) return col_pool[$urandom_range(0, POOL_SIZE - 1)];
    return COL_BITS'($urandom_range(0, (1 << COL_BITS) - 1));
  endfunction

  function automatic logic [VAL_BITS-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return $urandom();
  endfunction

  // offer one request and wait until it is taken
  task automatic send_request(input logic [1:0] op, input logic [COL_BITS-1:0] col,
                              input logic [VAL_BITS-1:0] word, input logic nul);
    int unsigned gap;
    gap = source_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {word, col, op};
    s_tuser  <= nul;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(op, col, word, nul);
  endtask

  // stop offering and wait until every owed reply has come back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.due_replies.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, optional long hold-off, check each accepted result
  initial begin : sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_tready   = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) tracker.check_reply(m_tdata, m_tuser);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        m_tready <= 1'b0;
      end else if (!sink_idle) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sorted_sparse_column_table_unit: mismatch");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    logic [1:0]  op;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    source_idle  = 1'b1;
    sink_idle    = 1'b1;
    hold_request = 0;

    col_pool[0] = '0;
    col_pool[1] = '1;
    for (n = 2; n < POOL_SIZE; n++) col_pool[n] = COL_BITS'($urandom_range(0, 16383));
    phase_mix = '{MIX_FILL, MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL,
                  MIX_BALANCED, MIX_DRAIN, MIX_DRAIN, MIX_FILL, MIX_BALANCED};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, insert and update paths, null values, extremes of the key
    send_request(OP_LOOKUP, '0, '0, 1'b0);             // lookup on empty table
    send_request(OP_ERASE, '1, '1, 1'b1);              // erase on empty table
    send_request(OP_TOUCH, 14'd100, 32'h1234_5678, 1'b0); // touch inserts null
    send_request(OP_TOUCH, 14'd100, '1, 1'b0);         // touch of present null entry
    send_request(OP_SET, 14'd100, 32'hA5A5_A5A5, 1'b0);   // update in place
    send_request(OP_TOUCH, 14'd100, '0, 1'b1);         // touch reports stored value
    send_request(OP_SET, '1, '1, 1'b0);                // highest key, full span
    send_request(OP_SET, '0, '0, 1'b0);                // lowest key, zero value
    send_request(OP_LOOKUP, '1, '0, 1'b0);
    send_request(OP_SET, '1, '1, 1'b1);                // set null drops the word
    send_request(OP_LOOKUP, '1, '1, 1'b1);
    send_request(OP_ERASE, '1, '0, 1'b0);              // span shrinks
    send_request(OP_ERASE, '1, '0, 1'b0);              // erase of missing key
    send_request(OP_SET, '0, 32'h5A5A_5A5A, 1'b0);
    send_request(OP_LOOKUP, '0, '0, 1'b0);
    send_request(OP_SET, 14'd8191, 32'hFFFF_0000, 1'b1); // insert null by set
    send_request(OP_LOOKUP, 14'd8190, '0, 1'b0);       // neighbor is absent
    send_request(OP_SET, 14'd8192, 32'h0000_FFFF, 1'b0);
    send_request(OP_ERASE, '0, '0, 1'b0);              // erase at the front
    send_request(OP_ERASE, 14'd8191, '0, 1'b0);        // erase in the middle
    send_request(OP_ERASE, 14'd8192, '0, 1'b0);
    send_request(OP_ERASE, 14'd100, '0, 1'b0);         // table empty again

    // random phases that fill, churn and drain the table
    for (ph = 0; ph < PHASES; ph++) begin
      source_idle = !(ph == 3 || ph == 7);
      sink_idle   = !(ph == 3 || ph == 7);
      if (ph == 2) begin
        // long receiver hold-off while requests keep coming
        source_idle  = 1'b0;
        hold_request = LONG_HOLD;
      end
      if (ph == 5) drain_replies();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        op = pick_op(phase_mix[ph]);
        send_request(op, pick_column(), pick_value(), $urandom_range(0, 3) == 0);
        if (ph == 2 && n == 20) source_idle = 1'b1;
      end
    end
    s_tvalid <= 1'b0;

    // let the last replies come back, then look for strays
    while (tracker.due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_replies.size() == 0) begin
      $display("sorted_sparse_column_table_unit: match");
    end else begin
      $display("sorted_sparse_column_table_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sscol_pkg.sv
sv/sscol_cell.sv
sv/sorted_sparse_column_table_unit.sv
sv/sscol_checker.sv
dv/sorted_sparse_column_table_unit_tb.sv
